@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Each is clocked on clk and disabled
// while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A condition that, when true, must be followed by another in the next cycle.
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/core/mprc_pkg.sv @@
// ---------------------------------------------------------------------------
// mprc_pkg
// Shared codes, reset values and types for the motor PWM ramp controller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mprc_pkg;

    // Operation codes of an input item.
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_SET_DIR = 2'd1;
    localparam logic [1:0] OP_SET_SPD = 2'd2;
    localparam logic [1:0] OP_STOP    = 2'd3;

    // Direction codes.
    localparam logic [2:0] DIR_FWD    = 3'd0;
    localparam logic [2:0] DIR_REV    = 3'd1;
    localparam logic [2:0] DIR_STOP   = 3'd2;
    localparam logic [2:0] DIR_LEFT   = 3'd3;
    localparam logic [2:0] DIR_RIGHT  = 3'd4;
    localparam logic [2:0] DIR_CENTER = 3'd5;

    // Bridge modes.
    localparam logic [1:0] MODE_FWD   = 2'd0;
    localparam logic [1:0] MODE_REV   = 2'd1;
    localparam logic [1:0] MODE_BRAKE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RAMP_STEP     = 2'd0;
    localparam logic [1:0] CFG_MIN_DUTY      = 2'd1;
    localparam logic [1:0] CFG_MAX_DUTY      = 2'd2;
    localparam logic [1:0] CFG_RAMP_INTERVAL = 2'd3;

    // Reset values.
    localparam logic [7:0]  RST_RAMP_STEP     = 8'd5;
    localparam logic [7:0]  RST_MIN_DUTY      = 8'd55;
    localparam logic [7:0]  RST_MAX_DUTY      = 8'd255;
    localparam logic [15:0] RST_RAMP_INTERVAL = 16'd19;
    localparam logic [15:0] RST_WAIT_COUNT    = 16'd500;

    // Duty written to the pin while braking.
    localparam logic [7:0] BRAKE_PIN_DUTY = 8'd255;

    // One result item.
    typedef struct packed {
        logic [7:0] duty_out;
        logic [1:0] bridge_mode;
        logic [7:0] present_duty;
        logic [2:0] present_direction;
        logic [2:0] goal_direction;
    } result_t;

endpackage

@@ rtl/core/motor_pwm_ramp_controller.sv @@
// ---------------------------------------------------------------------------
// motor_pwm_ramp_controller
// Soft-start duty ramp and direction control for one H-bridge motor.
// ---------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  input     in_valid / in_stall  operation, direction_code, speed_duty
//  result    out_valid/ out_stall duty_out, bridge_mode, present_duty,
//                                 present_direction, goal_direction
//  config    cfg_valid/ cfg_ready cfg_index, cfg_data
//
//  An item waits in the input register; the state update and its result are
//  formed from it and registered into the result buffer once the buffer has
//  room, so a stalled item stays in the input register.
//  One item is taken per cycle while results drain.
//  The result side has two entries (output register and skid register), so
//  input only stalls when both hold results and the input register is full.
//  Reset is asynchronous and puts all control state to its power-up values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module motor_pwm_ramp_controller
(
    input  logic        clk,
    input  logic        rst_n,
    // Input items.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [2:0]  direction_code,
    input  logic [7:0]  speed_duty,
    // Result items.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  duty_out,
    output logic [1:0]  bridge_mode,
    output logic [7:0]  present_duty,
    output logic [2:0]  present_direction,
    output logic [2:0]  goal_direction,
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Configuration registers.
    logic [7:0]  ramp_step_reg;
    logic [7:0]  min_duty_reg;
    logic [7:0]  max_duty_reg;
    logic [15:0] ramp_interval_reg;

    // Input register.
    logic        item_valid_reg;
    logic        item_valid_next;
    logic [1:0]  op_reg;
    logic [2:0]  code_reg;
    logic [7:0]  req_reg;

    // Controller state.
    logic [7:0]  cur_duty_reg,  cur_duty_next;
    logic [7:0]  goal_duty_reg, goal_duty_next;
    logic [7:0]  held_duty_reg, held_duty_next;
    logic [2:0]  cur_dir_reg,   cur_dir_next;
    logic [2:0]  goal_dir_reg,  goal_dir_next;
    logic [2:0]  prev_dir_reg,  prev_dir_next;
    logic [15:0] wait_reg,      wait_next;
    logic [7:0]  pin_duty_reg,  pin_duty_next;
    logic [1:0]  mode_reg,      mode_next;

    // Result buffer.
    logic [1:0]           cnt_reg, cnt_next;
    mprc_pkg::result_t    head_reg;
    mprc_pkg::result_t    skid_reg;
    mprc_pkg::result_t    res_new;

    logic        in_xfer;
    logic        advance;
    logic        pop;
    logic        full;

    // Ramp arithmetic.
    logic [9:0]  dn_diff;
    logic [7:0]  dn_duty;
    logic [8:0]  up_sum;
    logic [7:0]  up_duty;
    logic [7:0]  req_clamped;
    logic        stop_go;

    // Handshakes.
    assign cfg_ready = 1'b1;
    assign full      = (cnt_reg == 2'd2);
    assign advance   = item_valid_reg && !full;
    assign in_stall  = item_valid_reg && full;
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && !out_stall;

    assign item_valid_next = in_xfer || (item_valid_reg && !advance);

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_step_reg     <= mprc_pkg::RST_RAMP_STEP;
            min_duty_reg      <= mprc_pkg::RST_MIN_DUTY;
            max_duty_reg      <= mprc_pkg::RST_MAX_DUTY;
            ramp_interval_reg <= mprc_pkg::RST_RAMP_INTERVAL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mprc_pkg::CFG_RAMP_STEP:     ramp_step_reg     <= cfg_data[7:0];
                mprc_pkg::CFG_MIN_DUTY:      min_duty_reg      <= cfg_data[7:0];
                mprc_pkg::CFG_MAX_DUTY:      max_duty_reg      <= cfg_data[7:0];
                mprc_pkg::CFG_RAMP_INTERVAL: ramp_interval_reg <= cfg_data;
                default:                     ramp_step_reg     <= ramp_step_reg;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg   <= operation;
            code_reg <= direction_code;
            req_reg  <= speed_duty;
        end
    end

    // Speed request with deadband and clamp.
    always_comb
    begin
        if (req_reg < min_duty_reg)
        begin
            req_clamped = 8'd0;
        end
        else if (req_reg > max_duty_reg)
        begin
            req_clamped = max_duty_reg;
        end
        else
        begin
            req_clamped = req_reg;
        end
    end

    // A stop is ignored when one direction is stop and the other center.
    assign stop_go = (goal_dir_reg != mprc_pkg::DIR_STOP && cur_dir_reg != mprc_pkg::DIR_STOP)
                  || (goal_dir_reg != mprc_pkg::DIR_CENTER
                      && cur_dir_reg != mprc_pkg::DIR_CENTER);

    // Next state: command, then ramp step, then direction switch.
    always_comb
    begin
        cur_duty_next  = cur_duty_reg;
        goal_duty_next = goal_duty_reg;
        held_duty_next = held_duty_reg;
        cur_dir_next   = cur_dir_reg;
        goal_dir_next  = goal_dir_reg;
        prev_dir_next  = prev_dir_reg;
        wait_next      = wait_reg;
        pin_duty_next  = pin_duty_reg;
        mode_next      = mode_reg;
        dn_diff        = 10'd0;
        dn_duty        = 8'd0;
        up_sum         = 9'd0;
        up_duty        = 8'd0;

        // Apply the command.
        case (op_reg)
            mprc_pkg::OP_TICK:
            begin
                if (wait_reg != 16'd0)
                begin
                    wait_next = wait_reg - 16'd1;
                end
            end
            mprc_pkg::OP_SET_DIR:
            begin
                if (code_reg <= mprc_pkg::DIR_CENTER)
                begin
                    goal_dir_next = code_reg;
                    wait_next     = 16'd0;
                    if (code_reg != cur_dir_reg)
                    begin
                        goal_duty_next = 8'd0;
                        held_duty_next = 8'd0;
                    end
                end
            end
            mprc_pkg::OP_SET_SPD:
            begin
                if (cur_dir_reg == goal_dir_reg)
                begin
                    goal_duty_next = req_clamped;
                end
                else
                begin
                    held_duty_next = req_clamped;
                end
                if (cur_dir_reg == mprc_pkg::DIR_STOP && prev_dir_reg != mprc_pkg::DIR_STOP)
                begin
                    goal_dir_next = prev_dir_reg;
                end
                wait_next = 16'd0;
            end
            mprc_pkg::OP_STOP:
            begin
                if (stop_go)
                begin
                    goal_dir_next  = (code_reg > mprc_pkg::DIR_CENTER)
                                   ? mprc_pkg::DIR_STOP : code_reg;
                    goal_duty_next = 8'd0;
                    wait_next      = 16'd0;
                end
            end
            default:
            begin
                wait_next = wait_reg;
            end
        endcase

        // One ramp step toward the clamped goal when the countdown is done.
        if (wait_next == 16'd0 && cur_duty_reg != goal_duty_next)
        begin
            if (goal_duty_next > max_duty_reg)
            begin
                goal_duty_next = max_duty_reg;
            end
            if (cur_duty_reg > goal_duty_next)
            begin
                dn_diff = {2'b00, cur_duty_reg} - {2'b00, ramp_step_reg};
                if ($signed(dn_diff) <= $signed({2'b00, min_duty_reg}))
                begin
                    dn_duty = 8'd0;
                end
                else
                begin
                    dn_duty = dn_diff[7:0];
                end
                cur_duty_next = (dn_duty < goal_duty_next) ? goal_duty_next : dn_duty;
            end
            else if (cur_duty_reg < goal_duty_next)
            begin
                up_sum  = {1'b0, cur_duty_reg} + {1'b0, ramp_step_reg};
                up_duty = (up_sum > {1'b0, goal_duty_next}) ? goal_duty_next : up_sum[7:0];
                if (up_duty != 8'd0 && up_duty <= min_duty_reg)
                begin
                    up_duty = min_duty_reg;
                end
                cur_duty_next = up_duty;
            end
            pin_duty_next = cur_duty_next;
            wait_next     = ramp_interval_reg;
        end

        // Direction switch, only at zero duty.
        if (cur_duty_next == 8'd0 && cur_dir_reg != goal_dir_next)
        begin
            if (goal_dir_next inside {mprc_pkg::DIR_FWD, mprc_pkg::DIR_LEFT})
            begin
                mode_next = mprc_pkg::MODE_FWD;
            end
            else if (goal_dir_next inside {mprc_pkg::DIR_REV, mprc_pkg::DIR_RIGHT})
            begin
                mode_next = mprc_pkg::MODE_REV;
            end
            else
            begin
                cur_duty_next  = 8'd0;
                held_duty_next = 8'd0;
                pin_duty_next  = mprc_pkg::BRAKE_PIN_DUTY;
                mode_next      = mprc_pkg::MODE_BRAKE;
                prev_dir_next  = cur_dir_reg;
            end
            cur_dir_next   = goal_dir_next;
            goal_duty_next = held_duty_next;
            wait_next      = 16'd0;
        end
    end

    // Controller state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_duty_reg  <= 8'd0;
            goal_duty_reg <= 8'd0;
            held_duty_reg <= 8'd0;
            cur_dir_reg   <= mprc_pkg::DIR_STOP;
            goal_dir_reg  <= mprc_pkg::DIR_STOP;
            prev_dir_reg  <= mprc_pkg::DIR_FWD;
            wait_reg      <= mprc_pkg::RST_WAIT_COUNT;
            pin_duty_reg  <= 8'd0;
            mode_reg      <= mprc_pkg::MODE_FWD;
        end
        else if (advance)
        begin
            cur_duty_reg  <= cur_duty_next;
            goal_duty_reg <= goal_duty_next;
            held_duty_reg <= held_duty_next;
            cur_dir_reg   <= cur_dir_next;
            goal_dir_reg  <= goal_dir_next;
            prev_dir_reg  <= prev_dir_next;
            wait_reg      <= wait_next;
            pin_duty_reg  <= pin_duty_next;
            mode_reg      <= mode_next;
        end
    end

    // The result shows the state after the item.
    assign res_new = '{duty_out:          pin_duty_next,
                       bridge_mode:       mode_next,
                       present_duty:      cur_duty_next,
                       present_direction: cur_dir_next,
                       goal_direction:    goal_dir_next};

    // Result buffer occupancy.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (advance && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!advance && pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Output and skid registers.
    always_ff @(posedge clk)
    begin
        if (cnt_reg == 2'd2 && pop)
        begin
            head_reg <= skid_reg;
        end
        else if (advance && (cnt_reg == 2'd0 || pop))
        begin
            head_reg <= res_new;
        end
        if (advance && cnt_reg == 2'd1 && !pop)
        begin
            skid_reg <= res_new;
        end
    end

    assign duty_out          = head_reg.duty_out;
    assign bridge_mode       = head_reg.bridge_mode;
    assign present_duty      = head_reg.present_duty;
    assign present_direction = head_reg.present_direction;
    assign goal_direction    = head_reg.goal_direction;

    // Checks.
    `ASSERT_ALWAYS(a_cnt_bound, cnt_reg != 2'd3, "result buffer count out of range")
    `ASSERT_ALWAYS(a_cur_dir_legal, cur_dir_reg <= mprc_pkg::DIR_CENTER, "bad present direction")
    `ASSERT_ALWAYS(a_goal_dir_legal, goal_dir_reg <= mprc_pkg::DIR_CENTER, "bad goal direction")
    `ASSERT_NEXT(a_push_shows, advance && cnt_reg == 2'd0, out_valid, "no result shown")
    `ASSERT_NEXT(a_item_kept, item_valid_reg && full, item_valid_reg, "stalled item lost")

endmodule
